// File: rtl/terminal_cursor_tab_controller_defines.svh
// Assertion macros for the terminal cursor and tab-stop controller.
// Included by the top level; no other dependencies.
`ifndef TERMINAL_CURSOR_TAB_CONTROLLER_DEFINES_SVH
`define TERMINAL_CURSOR_TAB_CONTROLLER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on the rising clock edge outside reset.
`define TCTC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// Next-cycle implication, sampled on the rising clock edge outside reset.
`define TCTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define TCTC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TCTC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/tctc_pkg.sv
// Shared types, constants and helper functions of the cursor and tab-stop controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package tctc_pkg;

	// Geometry of the screen and the tab bitmap.
	localparam int MAX_COLS    = 256;
	localparam int MAX_ROWS    = 256;
	localparam int TAB_SPACING = 8;

	// Field widths.
	localparam int COL_W     = $clog2(MAX_COLS);
	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int DIM_W     = 9;
	localparam int AMT_W     = 10;
	localparam int NT_W      = 9;
	localparam int TCOL_W    = 8;
	localparam int OP_W      = 4;
	localparam int CFG_IDX_W = 1;
	// Signed work width for moves: holds cursor plus distance without overflow.
	localparam int S_W       = 12;

	// Tab search: bitmap split into groups of GROUP_W columns.
	localparam int GROUP_W    = 16;
	localparam int N_GROUPS   = MAX_COLS / GROUP_W;
	localparam int GRP_IDX_W  = $clog2(N_GROUPS);
	localparam int BIT_IDX_W  = $clog2(GROUP_W);

	// Reset values that follow from the reset geometry of 80 by 24.
	localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(80);
	localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(24);
	localparam logic [ROW_W-1:0] BOTTOM_RESET = ROW_W'(23);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = CFG_IDX_W'(1);

	// Command codes.
	typedef enum logic [OP_W-1:0] {
		OP_MOVE_ROW   = 4'd0,
		OP_MOVE_COL   = 4'd1,
		OP_SET_TAB    = 4'd2,
		OP_CLEAR_TAB  = 4'd3,
		OP_NEXT_TAB   = 4'd4,
		OP_SET_REGION = 4'd5,
		OP_SET_MODES  = 4'd6,
		OP_SAVE       = 4'd7,
		OP_RESTORE    = 4'd8,
		OP_SOFT_RESET = 4'd9
	} tctc_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;  // capture the incoming command word
		logic exec;   // apply the command to the cursor state
		logic scan;   // first stage of the tab search
		logic load;   // load the response register
	} tctc_ctrl_t;

	// Tab bitmap after reset: a stop every TAB_SPACING columns.
	function automatic logic [MAX_COLS-1:0] tab_reset_pattern();
		logic [MAX_COLS-1:0] p;
		p = '0;
		for (int i = 0; i < MAX_COLS; i++) begin
			p[i] = ((i % TAB_SPACING) == 0);
		end
		return p;
	endfunction

	// Zero-extend an unsigned coordinate into the signed work width.
	function automatic logic signed [S_W-1:0] to_s(logic [DIM_W-1:0] x);
		return $signed(S_W'(x));
	endfunction

	// Clamp a row to [lt, lb], top bound first.
	function automatic logic [ROW_W-1:0] snap_row(logic signed [S_W-1:0] r,
			logic [ROW_W-1:0] lt, logic [ROW_W-1:0] lb);
		logic signed [S_W-1:0] v;
		v = r;
		if (v < to_s(DIM_W'(lt))) v = to_s(DIM_W'(lt));
		if (v > to_s(DIM_W'(lb))) v = to_s(DIM_W'(lb));
		return ROW_W'(v);
	endfunction

	// Clamp a column to [0, wm1].
	function automatic logic [COL_W-1:0] snap_col(logic signed [S_W-1:0] c,
			logic [COL_W-1:0] wm1);
		logic signed [S_W-1:0] v;
		v = c;
		if (v < 0) v = '0;
		if (v > to_s(DIM_W'(wm1))) v = to_s(DIM_W'(wm1));
		return COL_W'(v);
	endfunction

endpackage

`default_nettype wire

// File: rtl/terminal_cursor_tab_controller.sv
// Terminal cursor and tab-stop controller: one command word in, one state word out.
// A command is taken when the block is idle and passes through the accept step, the
// execute step and the two-stage search of the 256-column tab bitmap (sixteen
// groups of sixteen columns, then the first group), before its response is loaded.
// The response sits in an output register; a new command may be accepted while
// it waits, and that command's response is held back until the register drains.
// Screen size writes reach the next execute or search step, even mid-command.
// Depends on tctc_pkg, tctc_ctrl, tctc_datapath and the assertion macro header.
`default_nettype none
`include "terminal_cursor_tab_controller_defines.svh"

module terminal_cursor_tab_controller (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Configuration write port.
	input  wire logic                              cfg_wr_en,
	input  wire logic [tctc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [tctc_pkg::DIM_W-1:0]        cfg_data,
	// Command channel.
	input  wire logic                              cmd_valid,
	output logic                                   cmd_stall,
	input  wire logic [tctc_pkg::OP_W-1:0]         opcode,
	input  wire logic signed [tctc_pkg::AMT_W-1:0] amount,
	input  wire logic                              is_relative,
	input  wire logic                              is_implicit,
	input  wire logic [tctc_pkg::TCOL_W-1:0]       tab_column,
	input  wire logic signed [tctc_pkg::AMT_W-1:0] region_top_in,
	input  wire logic signed [tctc_pkg::AMT_W-1:0] region_bottom_in,
	input  wire logic                              origin_mode_in,
	input  wire logic                              auto_wrap_in,
	// Response channel.
	output logic                                   rsp_valid,
	input  wire logic                              rsp_stall,
	output logic [tctc_pkg::ROW_W-1:0]             row_out,
	output logic [tctc_pkg::COL_W-1:0]             col_out,
	output logic                                   wrap_pending_out,
	output logic [tctc_pkg::ROW_W-1:0]             grapheme_row_out,
	output logic [tctc_pkg::COL_W-1:0]             grapheme_col_out,
	output logic signed [tctc_pkg::NT_W-1:0]       next_tab_out,
	output logic                                   origin_mode_out,
	output logic                                   auto_wrap_out,
	output logic [tctc_pkg::ROW_W-1:0]             region_top_out,
	output logic [tctc_pkg::ROW_W-1:0]             region_bottom_out
);
	import tctc_pkg::*;

	tctc_ctrl_t ctrl;

	// Sequencer.
	tctc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.ctrl      (ctrl)
	);

	// Cursor datapath.
	tctc_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctrl              (ctrl),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.opcode            (opcode),
		.amount            (amount),
		.is_relative       (is_relative),
		.is_implicit       (is_implicit),
		.tab_column        (tab_column),
		.region_top_in     (region_top_in),
		.region_bottom_in  (region_bottom_in),
		.origin_mode_in    (origin_mode_in),
		.auto_wrap_in      (auto_wrap_in),
		.row_out           (row_out),
		.col_out           (col_out),
		.wrap_pending_out  (wrap_pending_out),
		.grapheme_row_out  (grapheme_row_out),
		.grapheme_col_out  (grapheme_col_out),
		.next_tab_out      (next_tab_out),
		.origin_mode_out   (origin_mode_out),
		.auto_wrap_out     (auto_wrap_out),
		.region_top_out    (region_top_out),
		.region_bottom_out (region_bottom_out)
	);

	// An accepted word is always followed by its execute step.
	`TCTC_ASSERT_NEXT(a_latch_then_exec, clk, arst_n, cmd_valid && !cmd_stall, ctrl.exec)
	// Execute is followed by the first search stage.
	`TCTC_ASSERT_NEXT(a_exec_then_scan, clk, arst_n, ctrl.exec, ctrl.scan)
	// A response load always presents a valid word on the next cycle.
	`TCTC_ASSERT_NEXT(a_load_then_valid, clk, arst_n, ctrl.load, rsp_valid)
	// At most one step command at a time.
	`TCTC_ASSERT_IMPLY(a_steps_exclusive, clk, arst_n, 1'b1,
		$onehot0({ctrl.latch, ctrl.exec, ctrl.scan, ctrl.load}))

endmodule

`default_nettype wire

// File: rtl/tctc_ctrl.sv
// Sequencer of the cursor and tab-stop controller: command handshake, execute and
// search steps, and the response valid. Depends on tctc_pkg.
`default_nettype none

module tctc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_stall,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output tctc_pkg::tctc_ctrl_t     ctrl
);
	import tctc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   slot_free;

	// The response register can take a new word when empty or being drained.
	assign slot_free = !rsp_valid_q || !rsp_stall;

	assign cmd_stall  = (state_q != ST_IDLE);
	assign rsp_valid  = rsp_valid_q;

	// Step commands decoded from the state.
	assign ctrl.latch = (state_q == ST_IDLE) && cmd_valid;
	assign ctrl.exec  = (state_q == ST_EXEC);
	assign ctrl.scan  = (state_q == ST_SCAN);
	assign ctrl.load  = (state_q == ST_FINISH) && slot_free;

	// State and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			// A load sets the response valid; a taken word clears it.
			if (ctrl.load) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/tctc_tab_scan.sv
// Two-step search for the first tab stop right of the cursor and left of the edge.
// Depends on tctc_pkg.
`default_nettype none

module tctc_tab_scan (
	input  wire logic                                clk,
	input  wire logic                                scan_en,
	input  wire logic [tctc_pkg::MAX_COLS-1:0]       tabs,
	input  wire logic [tctc_pkg::COL_W-1:0]          cur_col,
	input  wire logic [tctc_pkg::DIM_W-1:0]          eff_w,
	output logic signed [tctc_pkg::NT_W-1:0]         next_tab
);
	import tctc_pkg::*;

	logic [N_GROUPS-1:0]  any_s1;
	logic [BIT_IDX_W-1:0] idx_s1 [N_GROUPS];

	logic [N_GROUPS-1:0]  grp_any;
	logic [BIT_IDX_W-1:0] grp_idx [N_GROUPS];
	logic [GRP_IDX_W-1:0] sel;
	logic                 found;

	// Per group: masked stops and the lowest hit inside the group.
	always_comb begin
		for (int g = 0; g < N_GROUPS; g++) begin
			grp_any[g] = 1'b0;
			grp_idx[g] = '0;
			for (int b = GROUP_W - 1; b >= 0; b--) begin
				if (tabs[g*GROUP_W + b]
						&& (DIM_W'(g*GROUP_W + b) > DIM_W'(cur_col))
						&& (DIM_W'(g*GROUP_W + b) < eff_w)) begin
					grp_any[g] = 1'b1;
					grp_idx[g] = BIT_IDX_W'(b);
				end
			end
		end
	end

	// First search stage.
	always_ff @(posedge clk) begin
		if (scan_en) begin
			any_s1 <= grp_any;
			for (int g = 0; g < N_GROUPS; g++) begin
				idx_s1[g] <= grp_idx[g];
			end
		end
	end

	// Second stage: lowest group with a hit.
	always_comb begin
		found = 1'b0;
		sel   = '0;
		for (int g = N_GROUPS - 1; g >= 0; g--) begin
			if (any_s1[g]) begin
				found = 1'b1;
				sel   = GRP_IDX_W'(g);
			end
		end
		next_tab = found ? $signed(NT_W'({sel, idx_s1[sel]})) : '1;
	end

endmodule

`default_nettype wire

// File: rtl/tctc_datapath.sv
// Cursor state, modes, region, saved copy, tab bitmap, screen size registers and the
// response register. Depends on tctc_pkg and tctc_tab_scan.
`default_nettype none

module tctc_datapath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire tctc_pkg::tctc_ctrl_t              ctrl,
	// Configuration.
	input  wire logic                              cfg_wr_en,
	input  wire logic [tctc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [tctc_pkg::DIM_W-1:0]        cfg_data,
	// Command word.
	input  wire logic [tctc_pkg::OP_W-1:0]         opcode,
	input  wire logic signed [tctc_pkg::AMT_W-1:0] amount,
	input  wire logic                              is_relative,
	input  wire logic                              is_implicit,
	input  wire logic [tctc_pkg::TCOL_W-1:0]       tab_column,
	input  wire logic signed [tctc_pkg::AMT_W-1:0] region_top_in,
	input  wire logic signed [tctc_pkg::AMT_W-1:0] region_bottom_in,
	input  wire logic                              origin_mode_in,
	input  wire logic                              auto_wrap_in,
	// Response word.
	output logic [tctc_pkg::ROW_W-1:0]             row_out,
	output logic [tctc_pkg::COL_W-1:0]             col_out,
	output logic                                   wrap_pending_out,
	output logic [tctc_pkg::ROW_W-1:0]             grapheme_row_out,
	output logic [tctc_pkg::COL_W-1:0]             grapheme_col_out,
	output logic signed [tctc_pkg::NT_W-1:0]       next_tab_out,
	output logic                                   origin_mode_out,
	output logic                                   auto_wrap_out,
	output logic [tctc_pkg::ROW_W-1:0]             region_top_out,
	output logic [tctc_pkg::ROW_W-1:0]             region_bottom_out
);
	import tctc_pkg::*;

	// Captured command word.
	tctc_op_t                op_q;
	logic signed [AMT_W-1:0] amount_q;
	logic                    rel_q;
	logic                    imp_q;
	logic [TCOL_W-1:0]       tcol_q;
	logic signed [AMT_W-1:0] rtop_q;
	logic signed [AMT_W-1:0] rbot_q;
	logic                    om_q;
	logic                    aw_q;

	// Screen size registers.
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;

	// Cursor state.
	logic [ROW_W-1:0]    row_q, grow_q, top_q, bot_q, srow_q;
	logic [COL_W-1:0]    col_q, gcol_q, scol_q;
	logic                wrap_q, origin_q, awrap_q, sawrap_q, sorigin_q;
	logic [MAX_COLS-1:0] tab_q;

	// Next state.
	logic [ROW_W-1:0]    n_row, n_grow, n_top, n_bot, n_srow;
	logic [COL_W-1:0]    n_col, n_gcol, n_scol;
	logic                n_wrap, n_origin, n_awrap, n_sawrap, n_sorigin;
	logic [MAX_COLS-1:0] n_tab;

	// Response register.
	logic [ROW_W-1:0]       rsp_row_q, rsp_grow_q, rsp_top_q, rsp_bot_q;
	logic [COL_W-1:0]       rsp_col_q, rsp_gcol_q;
	logic                   rsp_wrap_q, rsp_origin_q, rsp_awrap_q;
	logic signed [NT_W-1:0] rsp_nt_q;

	logic [DIM_W-1:0]       eff_w, eff_h;
	logic [COL_W-1:0]       wm1;
	logic [ROW_W-1:0]       hm1;
	logic signed [NT_W-1:0] scan_next;

	// Effective screen size, clamped to 1..MAX.
	always_comb begin
		if (width_q == '0) eff_w = DIM_W'(1);
		else if (width_q > DIM_W'(MAX_COLS)) eff_w = DIM_W'(MAX_COLS);
		else eff_w = width_q;
		if (height_q == '0) eff_h = DIM_W'(1);
		else if (height_q > DIM_W'(MAX_ROWS)) eff_h = DIM_W'(MAX_ROWS);
		else eff_h = height_q;
	end
	assign wm1 = COL_W'(eff_w - DIM_W'(1));
	assign hm1 = ROW_W'(eff_h - DIM_W'(1));

	// Command execution.
	always_comb begin
		logic [ROW_W-1:0]      lt, lb;
		logic signed [S_W-1:0] amt_s, pos_s, t_s, b_s;
		n_row = row_q;   n_col = col_q;   n_grow = grow_q; n_gcol = gcol_q;
		n_wrap = wrap_q; n_origin = origin_q; n_awrap = awrap_q;
		n_top = top_q;   n_bot = bot_q;   n_tab = tab_q;
		n_srow = srow_q; n_scol = scol_q; n_sawrap = sawrap_q; n_sorigin = sorigin_q;
		amt_s = S_W'(amount_q);
		lt    = origin_q ? top_q : '0;
		lb    = origin_q ? bot_q : hm1;
		pos_s = '0;
		t_s   = '0;
		b_s   = '0;
		case (op_q)
			OP_MOVE_ROW: begin
				pos_s  = rel_q ? (to_s(DIM_W'(row_q)) + amt_s) : (amt_s + to_s(DIM_W'(lt)));
				n_row  = snap_row(pos_s, lt, lb);
				n_col  = snap_col(to_s(DIM_W'(col_q)), wm1);
				n_grow = n_row;
				n_gcol = n_col;
				n_wrap = 1'b0;
			end
			OP_MOVE_COL: begin
				// A printed character marks the cell it was put in before moving.
				if (imp_q) begin
					n_grow = row_q;
					n_gcol = col_q;
				end
				pos_s = rel_q ? (to_s(DIM_W'(col_q)) + amt_s) : amt_s;
				if (imp_q && (pos_s >= to_s(eff_w))) n_wrap = 1'b1;
				n_row = snap_row(to_s(DIM_W'(row_q)), lt, lb);
				n_col = snap_col(pos_s, wm1);
				if (!imp_q) begin
					n_grow = n_row;
					n_gcol = n_col;
					n_wrap = 1'b0;
				end
			end
			OP_SET_TAB: begin
				n_tab[col_q] = 1'b1;
			end
			OP_CLEAR_TAB: begin
				n_tab[tcol_q] = 1'b0;
			end
			OP_SET_REGION: begin
				t_s = S_W'(rtop_q);
				b_s = S_W'(rbot_q);
				if (t_s < 0) t_s = '0;
				if (t_s > to_s(DIM_W'(hm1))) t_s = to_s(DIM_W'(hm1));
				if (b_s >= to_s(eff_h)) b_s = to_s(DIM_W'(hm1));
				if (b_s < t_s) b_s = t_s;
				n_top = ROW_W'(t_s);
				n_bot = ROW_W'(b_s);
				if (origin_q) begin
					n_row  = snap_row(to_s(DIM_W'(row_q)), n_top, n_bot);
					n_col  = snap_col(to_s(DIM_W'(col_q)), wm1);
					n_grow = n_row;
					n_gcol = n_col;
				end
			end
			OP_SET_MODES: begin
				n_origin = om_q;
				n_awrap  = aw_q;
			end
			OP_SAVE: begin
				n_srow    = row_q;
				n_scol    = col_q;
				n_sawrap  = awrap_q;
				n_sorigin = origin_q;
			end
			OP_RESTORE: begin
				// Limits follow the restored origin mode.
				n_origin = sorigin_q;
				n_awrap  = sawrap_q;
				n_row    = snap_row(to_s(DIM_W'(srow_q)), sorigin_q ? top_q : '0,
					sorigin_q ? bot_q : hm1);
				n_col    = snap_col(to_s(DIM_W'(scol_q)), wm1);
				n_grow   = n_row;
				n_gcol   = n_col;
			end
			OP_SOFT_RESET: begin
				n_origin  = 1'b0;
				n_top     = '0;
				n_bot     = hm1;
				n_srow    = '0;
				n_scol    = '0;
				n_sawrap  = 1'b1;
				n_sorigin = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// Command word capture.
	always_ff @(posedge clk) begin
		if (ctrl.latch) begin
			op_q     <= tctc_op_t'(opcode);
			amount_q <= amount;
			rel_q    <= is_relative;
			imp_q    <= is_implicit;
			tcol_q   <= tab_column;
			rtop_q   <= region_top_in;
			rbot_q   <= region_bottom_in;
			om_q     <= origin_mode_in;
			aw_q     <= auto_wrap_in;
		end
	end

	// Screen size registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_SCREEN_WIDTH:  width_q  <= cfg_data;
				CFG_SCREEN_HEIGHT: height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Cursor state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0; col_q <= '0; grow_q <= '0; gcol_q <= '0;
			wrap_q <= 1'b0; origin_q <= 1'b0; awrap_q <= 1'b1;
			top_q <= '0; bot_q <= BOTTOM_RESET;
			tab_q <= tab_reset_pattern();
			srow_q <= '0; scol_q <= '0; sawrap_q <= 1'b1; sorigin_q <= 1'b0;
		end else if (ctrl.exec) begin
			row_q <= n_row; col_q <= n_col; grow_q <= n_grow; gcol_q <= n_gcol;
			wrap_q <= n_wrap; origin_q <= n_origin; awrap_q <= n_awrap;
			top_q <= n_top; bot_q <= n_bot;
			tab_q <= n_tab;
			srow_q <= n_srow; scol_q <= n_scol; sawrap_q <= n_sawrap; sorigin_q <= n_sorigin;
		end
	end

	// Next tab stop search over the updated bitmap.
	tctc_tab_scan u_scan (
		.clk      (clk),
		.scan_en  (ctrl.scan),
		.tabs     (tab_q),
		.cur_col  (col_q),
		.eff_w    (eff_w),
		.next_tab (scan_next)
	);

	// Response register.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rsp_row_q    <= row_q;
			rsp_col_q    <= col_q;
			rsp_wrap_q   <= wrap_q;
			rsp_grow_q   <= grow_q;
			rsp_gcol_q   <= gcol_q;
			rsp_nt_q     <= scan_next;
			rsp_origin_q <= origin_q;
			rsp_awrap_q  <= awrap_q;
			rsp_top_q    <= top_q;
			rsp_bot_q    <= bot_q;
		end
	end

	assign row_out           = rsp_row_q;
	assign col_out           = rsp_col_q;
	assign wrap_pending_out  = rsp_wrap_q;
	assign grapheme_row_out  = rsp_grow_q;
	assign grapheme_col_out  = rsp_gcol_q;
	assign next_tab_out      = rsp_nt_q;
	assign origin_mode_out   = rsp_origin_q;
	assign auto_wrap_out     = rsp_awrap_q;
	assign region_top_out    = rsp_top_q;
	assign region_bottom_out = rsp_bot_q;

endmodule

`default_nettype wire
